@@ rtl/sil_pkg.sv @@
// Shared types and constants for the sorted insertion list.
// No dependencies; used by sil_cell, sorted_insertion_list and tb_top.
package sil_pkg;

    localparam int unsigned DEPTH   = 64;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DUMP   = 1'b1;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0]        t_count;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic ins;    // place the broadcast value
        logic shift;  // move contents one cell towards the head
    } t_ctrl;

endpackage

@@ rtl/sil_cell.sv @@
// One compare-and-shift cell of the sorted chain.
// Depends on sil_pkg for t_value and t_ctrl.
module sil_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sil_pkg::t_ctrl i_ctrl,
    input  sil_pkg::t_value i_value,
    input  sil_pkg::t_value i_left_value,
    input  logic           i_left_valid,
    input  logic           i_left_lt,
    input  sil_pkg::t_value i_right_value,
    input  logic           i_right_valid,
    output sil_pkg::t_value o_value,
    output logic           o_valid,
    output logic           o_lt
);

    sil_pkg::t_value r_value, n_value;
    logic            r_valid, n_valid;
    logic            lt;

    // Strictly less: an equal value lands after the stored one.
    assign lt = r_valid && (i_value < r_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctrl.ins) begin
            if (i_left_lt) begin
                n_value = i_left_value;
            end else if (lt || (!r_valid && i_left_valid)) begin
                n_value = i_value;
            end
            n_valid = r_valid || i_left_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_lt    = lt;

endmodule

@@ rtl/sorted_insertion_list.sv @@
// Sorted insertion list: a row of DEPTH compare-and-shift cells.
// Insert: busy stays low, so inserts may arrive every cycle while no dump is busy.
// Dump of n values: busy until the last is sent, one result per cycle, the first
// registered after busy; an empty dump gives one result and no busy time.
// Reset (synchronous, active low) empties the list and clears the overflow flag.
// Results are strobed by o_valid for one cycle; the receiver cannot stall.
module sorted_insertion_list (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_mode,
    input  sil_pkg::t_value i_value,
    output logic            o_valid,
    output sil_pkg::t_value o_out_value,
    output logic            o_is_last,
    output logic            o_is_empty,
    output logic            o_overflowed
);

    localparam int unsigned DEPTH = sil_pkg::DEPTH;

    sil_pkg::t_count r_count, n_count;
    logic            r_busy, n_busy;
    logic            r_ovf, n_ovf;
    logic            r_out_valid, n_out_valid;
    sil_pkg::t_value r_out_value, n_out_value;
    logic            r_is_last, n_is_last;
    logic            r_is_empty, n_is_empty;
    logic            r_out_ovf, n_out_ovf;

    sil_pkg::t_ctrl  ctrl;
    logic            accept;
    logic            full;

    sil_pkg::t_value cell_value [DEPTH];
    logic            cell_valid [DEPTH];
    logic            cell_lt    [DEPTH];

    assign accept = start && !r_busy;
    assign full   = (r_count == sil_pkg::t_count'(DEPTH));

    // Broadcast controls: place a value unless full; shift every dump cycle.
    always_comb begin
        ctrl.ins   = accept && (i_mode == sil_pkg::MODE_INSERT) && !full;
        ctrl.shift = r_busy;
    end

    // The chain: cell 0 is the head and holds the smallest value.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sil_pkg::t_value left_value;
        logic            left_valid;
        logic            left_lt;
        sil_pkg::t_value right_value;
        logic            right_valid;

        if (g == 0) begin : g_head
            assign left_value = '0;
            assign left_valid = 1'b1;
            assign left_lt    = 1'b0;
        end else begin : g_body
            assign left_value = cell_value[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_lt    = cell_lt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner
            assign right_value = cell_value[g+1];
            assign right_valid = cell_valid[g+1];
        end

        sil_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_value       (i_value),
            .i_left_value  (left_value),
            .i_left_valid  (left_valid),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .i_right_valid (right_valid),
            .o_value       (cell_value[g]),
            .o_valid       (cell_valid[g]),
            .o_lt          (cell_lt[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_busy      = r_busy;
        n_ovf       = r_ovf;
        n_out_valid = 1'b0;
        n_out_value = r_out_value;
        n_is_last   = r_is_last;
        n_is_empty  = r_is_empty;
        n_out_ovf   = r_out_ovf;

        if (r_busy) begin
            // Emit the head; the chain shifts towards it in the same cycle.
            n_out_valid = 1'b1;
            n_out_value = cell_value[0];
            n_is_last   = !cell_valid[1];
            n_is_empty  = 1'b0;
            n_out_ovf   = r_ovf;
            if (!cell_valid[1]) begin
                n_busy  = 1'b0;
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end else if (accept) begin
            if (i_mode == sil_pkg::MODE_DUMP) begin
                if (r_count == '0) begin
                    // Empty store: answer at once and drop the flag.
                    n_out_valid = 1'b1;
                    n_out_value = '0;
                    n_is_last   = 1'b1;
                    n_is_empty  = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_ovf       = 1'b0;
                end else begin
                    n_busy = 1'b1;
                end
            end else if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_is_last   <= n_is_last;
        r_is_empty  <= n_is_empty;
        r_out_ovf   <= n_out_ovf;
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_busy      <= n_busy;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    assign busy         = r_busy;
    assign o_valid      = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_is_last    = r_is_last;
    assign o_is_empty   = r_is_empty;
    assign o_overflowed = r_out_ovf;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_insertion_list: a directed table, then random request runs.
// Depends on sil_pkg and the sorted_insertion_list RTL; a shadow sorted list predicts untyped dumps.
module tb_top;
    import sil_pkg::*;

    // One dump result as the list emits it.
    typedef struct packed {
        t_value val;
        logic   last;
        logic   empty;
        logic   ovf;
    } t_result;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        logic    mode;
        t_value  value;
        logic    typed;
        t_result want;
    } t_row;

    localparam int DIR_N = 22;

    logic   i_clk     = 1'b0;
    logic   i_rst_n   = 1'b0;
    logic   start     = 1'b0;
    logic   req_mode  = MODE_INSERT;
    t_value req_value = '0;
    logic   busy;
    logic   o_valid;
    t_value o_out_value;
    logic   o_is_last;
    logic   o_is_empty;
    logic   o_overflowed;

    // Shadow copy of the list contents and its sticky flag.
    t_value  shadow_vals [DEPTH];
    int      shadow_len  = 0;
    logic    shadow_ovf  = 1'b0;

    // Dump results still to arrive, oldest first.
    t_result awaited_results [$];

    int errors       = 0;
    int results_seen = 0;
    int n_inserts    = 0;
    int n_dumps      = 0;
    int n_ovf_dumps  = 0;
    int idle_pct     = 16;

    // Directed rows: reset state, extremes, equal values, one-element dumps of the extremes,
    // and dumps of an emptied list. Typed rows carry their result in full.
    t_row dir_rows [DIR_N] = '{
        '{MODE_DUMP,   32'sd0,           1'b1, '{32'sd0, 1'b1, 1'b1, 1'b0}},
        '{MODE_INSERT, 32'sh7FFF_FFFF,   1'b0, '0},
        '{MODE_INSERT, 32'sh8000_0000,   1'b0, '0},
        '{MODE_INSERT, 32'sd0,           1'b0, '0},
        '{MODE_INSERT, -32'sd1,          1'b0, '0},
        '{MODE_INSERT, 32'sd5,           1'b0, '0},
        '{MODE_INSERT, 32'sd5,           1'b0, '0},
        '{MODE_INSERT, -32'sd5,          1'b0, '0},
        '{MODE_DUMP,   32'shFFFF_FFFF,   1'b0, '0},
        '{MODE_DUMP,   32'sd0,           1'b1, '{32'sd0, 1'b1, 1'b1, 1'b0}},
        '{MODE_INSERT, 32'sh8000_0000,   1'b0, '0},
        '{MODE_DUMP,   32'sd0,           1'b1, '{32'sh8000_0000, 1'b1, 1'b0, 1'b0}},
        '{MODE_INSERT, 32'sh7FFF_FFFF,   1'b0, '0},
        '{MODE_DUMP,   32'sd0,           1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0}},
        '{MODE_INSERT, 32'sd7,           1'b0, '0},
        '{MODE_INSERT, 32'sd7,           1'b0, '0},
        '{MODE_DUMP,   32'sh5555_5555,   1'b0, '0},
        '{MODE_INSERT, 32'sd100,         1'b0, '0},
        '{MODE_INSERT, -32'sd100,        1'b0, '0},
        '{MODE_INSERT, 32'sd100,         1'b0, '0},
        '{MODE_INSERT, 32'sd0,           1'b0, '0},
        '{MODE_DUMP,   32'shAAAA_AAAA,   1'b0, '0}
    };

    sorted_insertion_list dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (req_mode),
        .i_value      (req_value),
        .o_valid      (o_valid),
        .o_out_value  (o_out_value),
        .o_is_last    (o_is_last),
        .o_is_empty   (o_is_empty),
        .o_overflowed (o_overflowed)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Advance the shadow list by one accepted request and queue what a dump must emit.
    task automatic shadow_apply(logic m, t_value v, logic typed, t_result want);
        int pos;
        int i;
        pos = 0;
        if (m == MODE_INSERT) begin
            n_inserts++;
            if (shadow_len >= DEPTH) begin
                // full: drop the value, remember the loss
                shadow_ovf = 1'b1;
            end else begin
                // equal values stay ahead of the newcomer
                while (pos < shadow_len && shadow_vals[pos] <= v) pos++;
                for (i = shadow_len; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
                shadow_vals[pos] = v;
                shadow_len++;
            end
        end else begin
            n_dumps++;
            if (shadow_ovf) n_ovf_dumps++;
            if (typed) begin
                awaited_results.push_back(want);
            end else if (shadow_len == 0) begin
                awaited_results.push_back('{32'sd0, 1'b1, 1'b1, shadow_ovf});
            end else begin
                for (i = 0; i < shadow_len; i++)
                    awaited_results.push_back('{shadow_vals[i], (i == shadow_len - 1),
                                                 1'b0, shadow_ovf});
            end
            shadow_len = 0;
            shadow_ovf = 1'b0;
        end
    endtask

    // Present one request, hold it until the list takes it, then predict.
    // Entered and left at a rising edge; start gets one assignment per step.
    task automatic send_request(logic m, t_value v, logic typed, t_result want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        req_mode  <= m;
        req_value <= v;
        do @(posedge i_clk); while (busy);
        shadow_apply(m, v, typed, want);
    endtask

    // Hold the sender off until every queued result has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Mix of wide random values, a narrow band for duplicates and the extremes.
    function automatic t_value pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return t_value'($urandom);
        if (sel < 75) return t_value'($urandom_range(16)) - 32'sd8;
        if (sel < 85) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        if (sel < 92) return 32'sh8000_0000 + t_value'($urandom_range(3));
        return 32'sh7FFF_FFFF - t_value'($urandom_range(3));
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] want_v,
                               logic [VALUE_W-1:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            if (errors <= 40)
                $display("%0t ns: %s mismatch, expected %h, actual %h",
                         $time, name, want_v, got_v);
        end
    endtask

    // Results cannot be held off: take each strobe as it comes.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t ns: unexpected result, expected none, actual %h last %b",
                             $time, o_out_value, o_is_last);
            end else begin
                want = awaited_results.pop_front();
                check_field("out_value",  want.val, o_out_value);
                check_field("is_last",    {{(VALUE_W-1){1'b0}}, want.last},
                            {{(VALUE_W-1){1'b0}}, o_is_last});
                check_field("is_empty",   {{(VALUE_W-1){1'b0}}, want.empty},
                            {{(VALUE_W-1){1'b0}}, o_is_empty});
                check_field("overflowed", {{(VALUE_W-1){1'b0}}, want.ovf},
                            {{(VALUE_W-1){1'b0}}, o_overflowed});
            end
        end
    end

    initial begin
        int items;
        int seq;
        int k;
        int j;
        int drain_wait;
        items = 0;
        seq   = 0;

        // Hold reset, then release it once.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_request(dir_rows[r].mode, dir_rows[r].value, dir_rows[r].typed,
                         dir_rows[r].want);

        // Let the directed dumps finish before the random runs begin.
        drain_results();

        while (items < 170 - DIR_N) begin
            seq++;
            // keep one long stretch free of idle cycles
            idle_pct = (items >= 60 && items < 110) ? 0 : 16;
            if (seq == 3 || seq == 5) begin
                // fill the list: past the top once to raise the flag, with exactly DEPTH inserts once
                if (seq == 3) begin
                    drain_results();
                    k = DEPTH + $urandom_range(1, 4);
                end else begin
                    k = DEPTH;
                end
                for (j = 0; j < k; j++) send_request(MODE_INSERT, pick_value(), 1'b0, '0);
                send_request(MODE_DUMP, t_value'($urandom), 1'b0, '0);
                items += k + 1;
            end else if ($urandom_range(99) < 80) begin
                // well-formed run: a few inserts, then a dump
                k = $urandom_range(12);
                for (j = 0; j < k; j++) send_request(MODE_INSERT, pick_value(), 1'b0, '0);
                send_request(MODE_DUMP, t_value'($urandom), 1'b0, '0);
                items += k + 1;
            end else begin
                // noise: requests of random kind
                k = $urandom_range(1, 4);
                for (j = 0; j < k; j++)
                    send_request(logic'($urandom_range(1)), pick_value(), 1'b0, '0);
                items += k;
            end
        end

        // Drop start and wait for the last dump to drain, with a limit.
        start <= 1'b0;
        drain_wait = 0;
        while (awaited_results.size() != 0 && drain_wait < 5000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        if (awaited_results.size() != 0) begin
            errors += awaited_results.size();
            $display("%0t ns: %0d results never arrived", $time, awaited_results.size());
        end
        // watch a little longer for stray strobes
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("Run covered %0d inserts and %0d dumps (%0d with the overflow flag set),",
                 n_inserts, n_dumps, n_ovf_dumps);
        $display("with %0d results checked against the shadow list.", results_seen);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
